>>> hw/rtl/dgr_pkg.sv
// shared types and constants for the dash/gap relay sequencer
// used by dgr_remainder, dgr_ctrl, dgr_datapath and dash_gap_relay_sequencer_core
// no dependencies
package dgr_pkg;

  // relay bank
  localparam int RELAY_COUNT = 4;
  localparam int RELAY_W     = 2;
  localparam logic [31:0] TICK_MS = 32'd100;

  // field widths
  localparam int KIND_W    = 4;
  localparam int DIST_W    = 32;
  localparam int CNT_W     = 32;
  localparam int LEN_W     = 16;
  localparam int CYC_W     = LEN_W + 1;
  localparam int MODE_W    = 2;
  localparam int PHASE_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int S_DATA_W  = 40;
  localparam int M_DATA_W  = 136;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_DIST   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_START  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_PAUSE  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_RESUME = 4'd4;
  localparam logic [KIND_W-1:0] KIND_RESET  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_TICK   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_ON     = 4'd7;
  localparam logic [KIND_W-1:0] KIND_OFF    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_TOGGLE = 4'd9;
  localparam logic [KIND_W-1:0] KIND_STATS  = 4'd10;

  // phases
  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_PAINT = 2'd1;
  localparam logic [PHASE_W-1:0] PH_GAP   = 2'd2;

  // paint modes
  localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DASHED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOLID  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAINT_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PISTOL_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;     // latch the input item
    logic delta;    // form the distance step
    logic advance;  // move the cycle position, start the remainder
    logic commit;   // apply the item and load the result register
  } dgr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic adv_needed;
    logic div_needed;
    logic div_done;
  } dgr_stat_t;

endpackage

>>> hw/rtl/dgr_remainder.sv
// iterative remainder unit: 32-bit dividend by 17-bit divisor, one bit per cycle
// depends on dgr_pkg
module dgr_remainder
  import dgr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIST_W-1:0] dividend,
  input  logic [CYC_W-1:0]  divisor,
  output logic [CYC_W-1:0]  rem,
  output logic              done
);

  logic [DIST_W-1:0] quo;
  logic [4:0]        cnt;
  logic              busy;
  logic [CYC_W:0]    trial;
  logic [CYC_W:0]    diff;

  // restoring step: bring down the next dividend bit
  assign trial = {rem, quo[DIST_W-1]};
  assign diff  = trial - {1'b0, divisor};

  // shift register and step counter
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIST_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[CYC_W-1:0];
      end else begin
        rem <= trial[CYC_W-1:0];
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/dgr_ctrl.sv
// controller state machine of the relay sequencer
// depends on dgr_pkg
module dgr_ctrl
  import dgr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  dgr_stat_t stat,
  output dgr_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DELTA = 5'b00010,
    ST_ADV   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);

  // commands
  always_comb begin
    cmd.load    = s_tvalid && (state == ST_IDLE);
    cmd.delta   = (state == ST_DELTA);
    cmd.advance = (state == ST_ADV);
    cmd.commit  = (state == ST_DONE) && slot_free;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DELTA;
      end
      ST_DELTA: begin
        state_next = stat.adv_needed ? ST_ADV : ST_DONE;
      end
      ST_ADV: begin
        state_next = stat.div_needed ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/dgr_datapath.sv
// datapath of the relay sequencer: registers, run state, relay statistics,
// result register; depends on dgr_pkg and dgr_remainder
module dgr_datapath
  import dgr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dgr_cmd_t             cmd,
  output dgr_stat_t            stat,
  input  logic [KIND_W-1:0]    item_kind,
  input  logic [S_DATA_W-1:0]  item_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [LEN_W-1:0]     cfg_data,
  output logic [M_DATA_W-1:0]  result
);

  // configuration
  logic [MODE_W-1:0]      paint_mode;
  logic [LEN_W-1:0]       line_length;
  logic [LEN_W-1:0]       gap_length;
  logic [RELAY_COUNT-1:0] pistol_mask;
  logic [RELAY_COUNT-1:0] enable_mask;

  // latched item
  logic [KIND_W-1:0]  kind_q;
  logic [DIST_W-1:0]  dist_q;
  logic [RELAY_W-1:0] idx_q;

  // run state
  logic [DIST_W-1:0]      last_distance, last_distance_next;
  logic [DIST_W-1:0]      cycle_position, cycle_position_next;
  logic [PHASE_W-1:0]     phase_reg, phase_reg_next;
  logic                   run_flag, run_flag_next;
  logic                   pause_flag, pause_flag_next;
  logic [RELAY_COUNT-1:0] relay_on, relay_on_next;
  logic [CNT_W-1:0]       cycles_done, cycles_done_next;
  logic [CNT_W-1:0]       painted_total, painted_total_next;
  logic [CNT_W-1:0]       switch_on_counts [RELAY_COUNT];
  logic [CNT_W-1:0]       switch_on_counts_next [RELAY_COUNT];
  logic [CNT_W-1:0]       on_time_totals [RELAY_COUNT];
  logic [CNT_W-1:0]       on_time_totals_next [RELAY_COUNT];
  logic [DIST_W-1:0]      delta_q;

  logic                   active;
  logic                   dashed;
  logic [CYC_W-1:0]       cyc_len;
  logic [CYC_W-1:0]       rem;
  logic [CYC_W-1:0]       pos;
  logic                   div_done;
  logic [DIST_W:0]        dist_diff;
  logic [RELAY_COUNT-1:0] auto_set;
  logic                   idx_ok;

  assign active   = run_flag && !pause_flag && (paint_mode != MODE_MANUAL);
  assign dashed   = (paint_mode != MODE_SOLID);
  assign cyc_len  = {1'b0, line_length} + {1'b0, gap_length};
  assign pos      = (cyc_len == '0) ? '0 : rem;
  assign auto_set = pistol_mask & enable_mask;
  assign idx_ok   = int'(idx_q) < RELAY_COUNT;

  always_comb begin
    stat.adv_needed = (kind_q == KIND_DIST) && active;
    stat.div_needed = dashed;
    stat.div_done   = div_done;
  end

  // position within the line plus gap cycle
  dgr_remainder u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.advance && dashed),
    .dividend (cycle_position + delta_q),
    .divisor  (cyc_len),
    .rem      (rem),
    .done     (div_done)
  );

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= item_kind;
      dist_q <= item_data[DIST_W-1:0];
      idx_q  <= item_data[DIST_W+RELAY_W-1:DIST_W];
    end
  end

  // distance step, zero when the reading went backwards
  assign dist_diff = {1'b0, dist_q} - {1'b0, last_distance};

  always_ff @(posedge clk) begin
    if (cmd.delta) begin
      delta_q <= dist_diff[DIST_W] ? '0 : dist_diff[DIST_W-1:0];
    end
  end

  // next state of the run and the statistics
  always_comb begin
    logic want_on;
    last_distance_next  = last_distance;
    cycle_position_next = cycle_position;
    phase_reg_next      = phase_reg;
    run_flag_next       = run_flag;
    pause_flag_next     = pause_flag;
    relay_on_next       = relay_on;
    cycles_done_next    = cycles_done;
    painted_total_next  = painted_total;
    switch_on_counts_next = switch_on_counts;
    on_time_totals_next   = on_time_totals;
    want_on = 1'b0;

    if (cfg_we) begin
      // a mode change stops a run
      if (cfg_addr == REG_PAINT_MODE && run_flag) begin
        run_flag_next   = 1'b0;
        pause_flag_next = 1'b0;
        phase_reg_next  = PH_IDLE;
        relay_on_next   = '0;
      end
    end else if (cmd.delta) begin
      if (kind_q == KIND_DIST) last_distance_next = dist_q;
    end else if (cmd.advance) begin
      cycle_position_next = cycle_position + delta_q;
    end else if (cmd.commit) begin
      case (kind_q)
        KIND_DIST: begin
          if (active) begin
            if (!dashed || pos < {1'b0, line_length}) begin
              if (phase_reg != PH_PAINT) begin
                phase_reg_next = PH_PAINT;
                for (int i = 0; i < RELAY_COUNT; i++) begin
                  if (auto_set[i]) begin
                    relay_on_next[i] = 1'b1;
                    switch_on_counts_next[i] = switch_on_counts[i] + 32'd1;
                  end
                end
              end
              painted_total_next = painted_total + delta_q;
            end else if (phase_reg != PH_GAP) begin
              phase_reg_next   = PH_GAP;
              relay_on_next    = '0;
              cycles_done_next = cycles_done + 32'd1;
            end
          end
        end
        KIND_START: begin
          if (paint_mode != MODE_MANUAL) begin
            run_flag_next       = 1'b1;
            pause_flag_next     = 1'b0;
            phase_reg_next      = PH_PAINT;
            cycle_position_next = '0;
            for (int i = 0; i < RELAY_COUNT; i++) begin
              if (auto_set[i]) begin
                relay_on_next[i] = 1'b1;
                switch_on_counts_next[i] = switch_on_counts[i] + 32'd1;
              end
            end
          end
        end
        KIND_STOP: begin
          run_flag_next   = 1'b0;
          pause_flag_next = 1'b0;
          phase_reg_next  = PH_IDLE;
          relay_on_next   = '0;
        end
        KIND_PAUSE: begin
          if (run_flag) begin
            pause_flag_next = 1'b1;
            relay_on_next   = '0;
          end
        end
        KIND_RESUME: begin
          if (run_flag && pause_flag) pause_flag_next = 1'b0;
        end
        KIND_RESET: begin
          run_flag_next       = 1'b0;
          pause_flag_next     = 1'b0;
          phase_reg_next      = PH_IDLE;
          relay_on_next       = '0;
          cycles_done_next    = '0;
          painted_total_next  = '0;
          cycle_position_next = '0;
          last_distance_next  = '0;
          for (int i = 0; i < RELAY_COUNT; i++) begin
            switch_on_counts_next[i] = '0;
            on_time_totals_next[i]   = '0;
          end
        end
        KIND_TICK: begin
          for (int i = 0; i < RELAY_COUNT; i++) begin
            if (relay_on[i]) on_time_totals_next[i] = on_time_totals[i] + TICK_MS;
          end
        end
        KIND_ON, KIND_OFF, KIND_TOGGLE: begin
          if (idx_ok) begin
            want_on = (kind_q == KIND_ON) || (kind_q == KIND_TOGGLE && !relay_on[idx_q]);
            if (!want_on) begin
              relay_on_next[idx_q] = 1'b0;
            end else if (enable_mask[idx_q]) begin
              relay_on_next[idx_q] = 1'b1;
              switch_on_counts_next[idx_q] = switch_on_counts[idx_q] + 32'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      paint_mode  <= MODE_MANUAL;
      line_length <= 16'd1000;
      gap_length  <= 16'd1000;
      pistol_mask <= '1;
      enable_mask <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PAINT_MODE:  paint_mode  <= cfg_data[MODE_W-1:0];
        REG_LINE_LENGTH: line_length <= cfg_data;
        REG_GAP_LENGTH:  gap_length  <= cfg_data;
        REG_PISTOL_MASK: pistol_mask <= cfg_data[RELAY_COUNT-1:0];
        REG_ENABLE_MASK: enable_mask <= cfg_data[RELAY_COUNT-1:0];
        default: begin
        end
      endcase
    end
  end

  // run state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_distance  <= '0;
      cycle_position <= '0;
      phase_reg      <= PH_IDLE;
      run_flag       <= 1'b0;
      pause_flag     <= 1'b0;
      relay_on       <= '0;
      cycles_done    <= '0;
      painted_total  <= '0;
      for (int i = 0; i < RELAY_COUNT; i++) begin
        switch_on_counts[i] <= '0;
        on_time_totals[i]   <= '0;
      end
    end else begin
      last_distance    <= last_distance_next;
      cycle_position   <= cycle_position_next;
      phase_reg        <= phase_reg_next;
      run_flag         <= run_flag_next;
      pause_flag       <= pause_flag_next;
      relay_on         <= relay_on_next;
      cycles_done      <= cycles_done_next;
      painted_total    <= painted_total_next;
      switch_on_counts <= switch_on_counts_next;
      on_time_totals   <= on_time_totals_next;
    end
  end

  // result register, loaded with the state after the item
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result[3:0]     <= relay_on_next;
      result[5:4]     <= phase_reg_next;
      result[6]       <= run_flag_next;
      result[7]       <= pause_flag_next;
      result[39:8]    <= cycles_done_next;
      result[71:40]   <= painted_total_next;
      result[103:72]  <= idx_ok ? switch_on_counts_next[idx_q] : '0;
      result[135:104] <= idx_ok ? on_time_totals_next[idx_q] : '0;
    end
  end

endmodule

>>> hw/rtl/dash_gap_relay_sequencer_core.sv
// top level of the distance-driven dash/gap relay sequencer
// depends on dgr_pkg, dgr_ctrl, dgr_datapath (with dgr_remainder)
//
// Usage: items enter on the s_ stream (odometer readings and commands, kind in
// s_tuser), one result per item leaves on the m_ stream with the relay state,
// phase, run flags and counters. Registers are written on the cfg_ channel,
// which is always ready; write only while no item is in flight.
// Sequence: a command, or a reading that does not advance a run (stopped,
// paused or manual mode), passes the DELTA and DONE states after its transfer
// and is loaded into the output register in DONE; a reading in solid mode also
// passes ADV before DONE; a reading in a dashed mode passes ADV and then waits
// in DIV for the remainder unit that reduces the cycle position modulo line
// plus gap one bit per cycle (32 steps). One item is worked on at a time: the
// next transfer is taken in the cycle after the previous result is loaded.
// When the receiver stalls, the result waits in the output register; the next
// item is still taken and processed and then waits for that register to free.
// Reset (rst, synchronous) loads the register defaults (manual mode, 1000 mm
// line and gap, all pistols enabled), stops the run and clears all counters.
module dash_gap_relay_sequencer_core
  import dgr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input items
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // distance_mm[31:0], relay_index[33:32], zeros
  input  logic [KIND_W-1:0]    s_tuser,   // kind[3:0]
  // results
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // relay_mask[3:0], phase[5:4], running[6],
                                          // paused[7], cycle_count[39:8],
                                          // painted_mm[71:40], activation_count[103:72],
                                          // active_time_ms[135:104]
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [LEN_W-1:0]     cfg_data
);

  dgr_cmd_t  cmd;
  dgr_stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencing
  dgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // state and arithmetic
  dgr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item_kind (s_tuser),
    .item_data (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .result    (m_tdata)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for dash_gap_relay_sequencer_core: odometer and command
// streams in, relay status out, all checked against a cycle-free status predictor
// depends on dgr_pkg and the dash_gap_relay_sequencer_core rtl
module tb;
  import dgr_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int CYCLE_LIMIT = 1000000;

  // first and last kind codes with no defined action
  localparam logic [KIND_W-1:0] KINDIDX_UNUSED_LO = 4'd11;
  localparam logic [KIND_W-1:0] KINDIDX_UNUSED_HI = 4'd15;

  // register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // result fields, last field in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]       active_time_ms;
    logic [CNT_W-1:0]       activation_count;
    logic [CNT_W-1:0]       painted_mm;
    logic [CNT_W-1:0]       cycle_count;
    logic                   paused;
    logic                   running;
    logic [PHASE_W-1:0]     phase;
    logic [RELAY_COUNT-1:0] relay_mask;
  } relay_status_t;

  // tracks relay state and counters, keeps the statuses still owed by the block
  class relay_status_tracker;
    logic [MODE_W-1:0]      mode;
    logic [LEN_W-1:0]       line_len;
    logic [LEN_W-1:0]       gap_len;
    logic [RELAY_COUNT-1:0] pistols;
    logic [RELAY_COUNT-1:0] enables;
    logic [DIST_W-1:0]      last_dist;
    logic [DIST_W-1:0]      cyc_pos;
    logic [PHASE_W-1:0]     ph;
    logic                   run;
    logic                   held;
    logic [RELAY_COUNT-1:0] relays;
    logic [CNT_W-1:0]       cycles;
    logic [CNT_W-1:0]       painted;
    logic [CNT_W-1:0]       on_count [RELAY_COUNT];
    logic [CNT_W-1:0]       on_ms [RELAY_COUNT];
    relay_status_t          status_due [$];
    int                     errors;

    function new();
      errors = 0;
      mode = MODE_MANUAL;
      line_len = 16'd1000;
      gap_len = 16'd1000;
      pistols = '1;
      enables = '1;
      clear_run();
    endfunction

    function void halt_run();
      run = 1'b0;
      held = 1'b0;
      ph = PH_IDLE;
      relays = '0;
    endfunction

    // stop plus wipe of position and every counter
    function void clear_run();
      halt_run();
      cycles = '0;
      painted = '0;
      cyc_pos = '0;
      last_dist = '0;
      for (int i = 0; i < RELAY_COUNT; i++) begin
        on_count[i] = '0;
        on_ms[i] = '0;
      end
    endfunction

    // every pistol that is used and enabled switches on and counts, even if on
    function void fire_pistols();
      for (int i = 0; i < RELAY_COUNT; i++) begin
        if (pistols[i] && enables[i]) begin
          relays[i] = 1'b1;
          on_count[i] = on_count[i] + 1;
        end
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] addr, logic [LEN_W-1:0] data);
      case (addr)
        REG_PAINT_MODE: begin
          mode = data[MODE_W-1:0];
          if (run) halt_run();
        end
        REG_LINE_LENGTH: line_len = data;
        REG_GAP_LENGTH:  gap_len = data;
        REG_PISTOL_MASK: pistols = data[RELAY_COUNT-1:0];
        REG_ENABLE_MASK: enables = data[RELAY_COUNT-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(logic [KIND_W-1:0] kind, logic [DIST_W-1:0] odo_mm,
                            logic [RELAY_W-1:0] idx);
      logic [DIST_W-1:0] delta;
      logic [DIST_W-1:0] cyc;
      logic [DIST_W-1:0] pos;
      logic              want_on;
      relay_status_t     st;
      case (kind)
        KIND_DIST: begin
          // backward readings give no progress
          delta = (odo_mm >= last_dist) ? odo_mm - last_dist : '0;
          last_dist = odo_mm;
          if (run && !held && mode != MODE_MANUAL) begin
            cyc_pos = cyc_pos + delta;
            cyc = DIST_W'(line_len) + DIST_W'(gap_len);
            pos = (cyc != 0) ? cyc_pos % cyc : '0;
            if (mode == MODE_SOLID || pos < DIST_W'(line_len)) begin
              if (ph != PH_PAINT) begin
                ph = PH_PAINT;
                fire_pistols();
              end
              painted = painted + delta;
            end else if (ph != PH_GAP) begin
              ph = PH_GAP;
              relays = '0;
              cycles = cycles + 1;
            end
          end
        end
        KIND_START: begin
          if (mode != MODE_MANUAL) begin
            run = 1'b1;
            held = 1'b0;
            ph = PH_PAINT;
            cyc_pos = '0;
            fire_pistols();
          end
        end
        KIND_STOP: halt_run();
        KIND_PAUSE: begin
          if (run) begin
            held = 1'b1;
            relays = '0;
          end
        end
        // relays stay dark until the next phase change
        KIND_RESUME: if (run && held) held = 1'b0;
        KIND_RESET: clear_run();
        KIND_TICK: begin
          for (int i = 0; i < RELAY_COUNT; i++)
            if (relays[i]) on_ms[i] = on_ms[i] + TICK_MS;
        end
        KIND_ON, KIND_OFF, KIND_TOGGLE: begin
          want_on = (kind == KIND_ON) || (kind == KIND_TOGGLE && !relays[idx]);
          if (!want_on) begin
            relays[idx] = 1'b0;
          end else if (enables[idx]) begin
            relays[idx] = 1'b1;
            on_count[idx] = on_count[idx] + 1;
          end
        end
        default: ;
      endcase
      st.relay_mask = relays;
      st.phase = ph;
      st.running = run;
      st.paused = held;
      st.cycle_count = cycles;
      st.painted_mm = painted;
      st.activation_count = on_count[idx];
      st.active_time_ms = on_ms[idx];
      status_due.push_back(st);
    endfunction

    function void compare(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(logic [M_DATA_W-1:0] data);
      relay_status_t got;
      relay_status_t want;
      if (status_due.size() == 0) begin
        $error("result transfer with nothing expected: 0x%0h", data);
        errors++;
        return;
      end
      got = relay_status_t'(data);
      want = status_due.pop_front();
      compare("relay_mask", CNT_W'(want.relay_mask), CNT_W'(got.relay_mask));
      compare("phase", CNT_W'(want.phase), CNT_W'(got.phase));
      compare("running", CNT_W'(want.running), CNT_W'(got.running));
      compare("paused", CNT_W'(want.paused), CNT_W'(got.paused));
      compare("cycle_count", want.cycle_count, got.cycle_count);
      compare("painted_mm", want.painted_mm, got.painted_mm);
      compare("activation_count", want.activation_count, got.activation_count);
      compare("active_time_ms", want.active_time_ms, got.active_time_ms);
    endfunction

    function int pending();
      return status_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [LEN_W-1:0]     cfg_data = '0;

  relay_status_tracker tracker = new();
  int  items_sent = 0;
  int  cycle_cnt = 0;
  int  rx_hold = 0;
  int  rx_roll;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;

  dash_gap_relay_sequencer_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("dash_gap_relay_sequencer_core verification failed");
      $finish;
    end
  end

  // receiver backpressure: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (rx_steady) begin
      m_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 70) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_hold <= (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  // both stream transfers are observed on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        tracker.take_item(s_tuser, s_tdata[DIST_W-1:0], s_tdata[DIST_W +: RELAY_W]);
      if (m_tvalid && m_tready)
        tracker.match_result(m_tdata);
    end
  end

  function automatic int tx_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 15) return LEN_W'(1);
    if (r < 75) return LEN_W'($urandom_range(1, 300));
    return LEN_W'($urandom_range(0, 65535));
  endfunction

  // one input transfer, valid kept high when no gap follows
  task automatic send_item(logic [KIND_W-1:0] kind, logic [DIST_W-1:0] odo_mm,
                           logic [RELAY_W-1:0] idx);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {{(S_DATA_W-DIST_W-RELAY_W){1'b0}}, idx, odo_mm};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    gap = tx_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every owed status has come back
  task automatic wait_all_results(int extra);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] addr, logic [LEN_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.write_reg(addr, data);
  endtask

  initial begin
    int                phase_no;
    int                n;
    int                r;
    int                span;
    logic [DIST_W-1:0] odo;
    logic [31:0]       word;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // manual commands and odd kinds in the reset configuration
    send_item(KIND_STATS, '0, 2'd0);
    send_item(KIND_ON, '0, 2'd0);
    send_item(KIND_TOGGLE, '0, 2'd1);
    send_item(KIND_TICK, '0, 2'd1);
    send_item(KIND_OFF, '0, 2'd0);
    send_item(KIND_TOGGLE, '0, 2'd1);
    send_item(KIND_ON, '0, 2'd3);
    send_item(KINDIDX_UNUSED_LO, '0, 2'd2);
    send_item(KINDIDX_UNUSED_HI, '1, 2'd3);
    // start is ignored in manual mode, pause and resume need a run
    send_item(KIND_START, '0, 2'd0);
    send_item(KIND_PAUSE, '0, 2'd0);
    send_item(KIND_RESUME, '0, 2'd0);
    send_item(KIND_DIST, '1, 2'd0);
    send_item(KIND_DIST, '0, 2'd0);
    wait_all_results(4);

    // short dashes, one used pistol not enabled
    write_reg(REG_PAINT_MODE, LEN_W'(MODE_DASHED));
    write_reg(REG_LINE_LENGTH, 16'd3);
    write_reg(REG_GAP_LENGTH, 16'd2);
    write_reg(REG_PISTOL_MASK, 16'hb);
    write_reg(REG_ENABLE_MASK, 16'h7);
    send_item(KIND_START, '0, 2'd2);
    send_item(KIND_DIST, 32'd1, 2'd0);
    send_item(KIND_DIST, 32'd3, 2'd1);
    send_item(KIND_DIST, 32'd5, 2'd0);
    send_item(KIND_PAUSE, '0, 2'd0);
    send_item(KIND_DIST, 32'd6, 2'd0);
    // resume leaves relays off while still in the dash
    send_item(KIND_RESUME, '0, 2'd0);
    send_item(KIND_DIST, 32'd7, 2'd0);
    send_item(KIND_DIST, 32'd9, 2'd1);
    send_item(KIND_ON, '0, 2'd3);
    send_item(KIND_RESET, '0, 2'd0);

    odo = '0;
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_all_results(4);
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);

      // fixed corner settings first, then random ones
      case (phase_no)
        0: begin
          write_reg(REG_PAINT_MODE, LEN_W'(MODE_SOLID));
          write_reg(REG_LINE_LENGTH, 16'd1000);
          write_reg(REG_GAP_LENGTH, 16'd1000);
          write_reg(REG_PISTOL_MASK, 16'hf);
          write_reg(REG_ENABLE_MASK, 16'hf);
        end
        1: begin
          // zero cycle length keeps the run in the gap
          write_reg(REG_PAINT_MODE, LEN_W'(MODE_DOUBLE));
          write_reg(REG_LINE_LENGTH, 16'd0);
          write_reg(REG_GAP_LENGTH, 16'd0);
          write_reg(REG_PISTOL_MASK, 16'hfff5);
          write_reg(REG_ENABLE_MASK, 16'hf);
        end
        2: begin
          write_reg(REG_PAINT_MODE, LEN_W'(MODE_DASHED));
          write_reg(REG_LINE_LENGTH, 16'hffff);
          write_reg(REG_GAP_LENGTH, 16'hffff);
          write_reg(REG_PISTOL_MASK, 16'h5);
          write_reg(REG_ENABLE_MASK, 16'hfffe);
        end
        3: begin
          write_reg(REG_PAINT_MODE, 16'hfffd);
          write_reg(REG_LINE_LENGTH, 16'd1);
          write_reg(REG_GAP_LENGTH, 16'd0);
          write_reg(REG_PISTOL_MASK, 16'hf);
          write_reg(REG_ENABLE_MASK, 16'hf);
        end
        4: begin
          write_reg(REG_PAINT_MODE, LEN_W'(MODE_MANUAL));
          write_reg(REG_LINE_LENGTH, 16'd1000);
          write_reg(REG_GAP_LENGTH, 16'hffff);
          write_reg(REG_PISTOL_MASK, 16'h0);
          write_reg(REG_ENABLE_MASK, 16'h0);
        end
        5: begin
          write_reg(REG_PAINT_MODE, LEN_W'(MODE_DOUBLE));
          write_reg(REG_LINE_LENGTH, 16'hffff);
          write_reg(REG_GAP_LENGTH, 16'd0);
          write_reg(REG_PISTOL_MASK, 16'hf);
          write_reg(REG_ENABLE_MASK, 16'ha);
          write_reg(REG_UNUSED_LO, 16'hffff);
        end
        default: begin
          word = $urandom;
          if ($urandom_range(0, 9) < 8)
            write_reg(REG_PAINT_MODE, ($urandom_range(0, 3) == 0) ?
                      word[15:0] : LEN_W'($urandom_range(0, 3)));
          if ($urandom_range(0, 1) == 0) write_reg(REG_LINE_LENGTH, pick_length());
          if ($urandom_range(0, 1) == 0) write_reg(REG_GAP_LENGTH, pick_length());
          word = $urandom;
          if ($urandom_range(0, 2) == 0)
            write_reg(REG_PISTOL_MASK, ($urandom_range(0, 3) == 0) ?
                      word[15:0] : LEN_W'($urandom_range(0, 15)));
          word = $urandom;
          if ($urandom_range(0, 2) == 0)
            write_reg(REG_ENABLE_MASK, ($urandom_range(0, 3) == 0) ?
                      word[31:16] : LEN_W'($urandom_range(0, 15)));
          if ($urandom_range(0, 15) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                      LEN_W'($urandom));
        end
      endcase

      // a run with random content: mostly forward readings, some commands and noise
      if (tracker.mode == MODE_SOLID) span = 500;
      else span = (int'(tracker.line_len) + int'(tracker.gap_len)) / 3 + 1;
      if (tracker.mode != MODE_MANUAL && $urandom_range(0, 4) != 0)
        send_item(KIND_START, '0, RELAY_W'($urandom_range(0, 3)));
      n = $urandom_range(10, 60);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 60 || r >= 93) begin
          odo = odo + DIST_W'($urandom_range(0, span));
          send_item(KIND_DIST, odo, RELAY_W'($urandom_range(0, 3)));
        end else if (r < 64) begin
          odo = odo - DIST_W'($urandom_range(1, 1000));
          send_item(KIND_DIST, odo, RELAY_W'($urandom_range(0, 3)));
        end else if (r < 66) begin
          odo = $urandom;
          send_item(KIND_DIST, odo, RELAY_W'($urandom_range(0, 3)));
        end else if (r < 71) begin
          send_item(KIND_TICK, $urandom, RELAY_W'($urandom_range(0, 3)));
        end else if (r < 74) begin
          send_item(KIND_PAUSE, $urandom, RELAY_W'($urandom_range(0, 3)));
        end else if (r < 78) begin
          send_item(KIND_RESUME, $urandom, RELAY_W'($urandom_range(0, 3)));
        end else if (r < 79) begin
          send_item(KIND_STOP, $urandom, RELAY_W'($urandom_range(0, 3)));
        end else if (r < 80) begin
          send_item(KIND_START, $urandom, RELAY_W'($urandom_range(0, 3)));
        end else if (r < 81) begin
          send_item(KIND_RESET, $urandom, RELAY_W'($urandom_range(0, 3)));
          odo = '0;
        end else if (r < 89) begin
          send_item(KIND_W'($urandom_range(KIND_ON, KIND_TOGGLE)), $urandom,
                    RELAY_W'($urandom_range(0, 3)));
        end else if (r < 92) begin
          send_item(KIND_STATS, $urandom, RELAY_W'($urandom_range(0, 3)));
        end else begin
          send_item(KIND_W'($urandom_range(KINDIDX_UNUSED_LO, KINDIDX_UNUSED_HI)), $urandom,
                    RELAY_W'($urandom_range(0, 3)));
        end
        // sender holds off until the block has caught up
        if ($urandom_range(0, 49) == 0) wait_all_results(1);
      end
      phase_no++;
    end

    wait_all_results(40);
    if (tracker.errors == 0) begin
      $display("dash_gap_relay_sequencer_core verification clean");
    end else begin
      $display("dash_gap_relay_sequencer_core verification failed");
    end
    $finish;
  end

endmodule

>>> dash_gap_relay_sequencer_core.f
hw/rtl/dgr_pkg.sv
hw/rtl/dgr_remainder.sv
hw/rtl/dgr_ctrl.sv
hw/rtl/dgr_datapath.sv
hw/rtl/dash_gap_relay_sequencer_core.sv
tb/tb.sv
